>>> hdl/mbe_pkg.sv
// Package for the Mandelbrot escape-time counter.
// Widths, fixed-point types, register indexes and the saturation helper.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mbe_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int COORD_BITS = 12;
    localparam int ITER_BITS  = 16;

    localparam int VAL_W  = 32;               // Q4.28 coordinate
    localparam int STEP_W = 31;
    localparam int OP_W   = VAL_W + 1;        // multiplier operand
    localparam int PROD_W = 2 * OP_W;
    localparam int SQ_W   = 2 * VAL_W - FRAC_BITS + 1; // scaled square or cross term
    localparam int SUM_W  = VAL_W + COORD_BITS + 2;    // widest sum before saturation
    localparam int IDX_W  = 3;
    localparam int CFG_W  = 32;

    typedef logic signed [VAL_W-1:0]  val_t;
    typedef logic        [STEP_W-1:0] step_t;
    typedef logic signed [OP_W-1:0]   op_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [SQ_W-1:0]   sq_t;
    typedef logic signed [SUM_W-1:0]  sum_t;
    typedef logic [COORD_BITS-1:0]    coord_t;
    typedef logic [ITER_BITS-1:0]     iter_t;

    // register indexes
    localparam logic [IDX_W-1:0] REG_X_MIN    = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_STEP   = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_MIN    = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_STEP   = 3'd3;
    localparam logic [IDX_W-1:0] REG_MAX_ITER = 3'd4;

    localparam val_t  X_MIN_RST    = 32'shE000_0000;  // -2.0
    localparam step_t X_STEP_RST   = 31'd786432;
    localparam val_t  Y_MIN_RST    = 32'shE800_0000;  // -1.5
    localparam step_t Y_STEP_RST   = 31'd786432;
    localparam iter_t MAX_ITER_RST = ITER_BITS'(255);

    localparam sum_t ESC_LIMIT = sum_t'(SUM_W'(4) << FRAC_BITS);

    localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    // clamp a wide sum into the signed coordinate range
    function automatic val_t sat_val(input sum_t v);
        logic [SUM_W-VAL_W:0] top;
        top = v[SUM_W-1:VAL_W-1];
        if ((&top) || (~|top)) begin
            return v[VAL_W-1:0];
        end else if (v[SUM_W-1]) begin
            return VAL_MIN;
        end else begin
            return VAL_MAX;
        end
    endfunction

endpackage

`default_nettype wire

>>> hdl/mandelbrot_escape_count.sv
// Mandelbrot escape-time counter: top level with sequencer and register file.
// Depends on mbe_pkg and mbe_mult.
// Per pixel: setup of c in states PX, PY and PC, then per iteration SQR, SQI, CRS and UPD;
//   the pixel ends when the limit is reached in SQR or when it escapes in CRS.
// Throughput: one pixel at a time; the next is taken once the result is in the
//   output register. Reset: aresetn synchronous active low, registers to defaults.
`timescale 1ns / 1ps
`default_nettype none

module mandelbrot_escape_count (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // config write port
    input  wire logic                       cfg_wr_en,
    input  wire logic [mbe_pkg::IDX_W-1:0]  cfg_index,
    input  wire logic [mbe_pkg::CFG_W-1:0]  cfg_wdata,
    // input stream
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [23:0]                s_tdata,   // column[11:0], row[23:12]
    // result stream
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [15:0]                     m_tdata    // iter_count[15:0]
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PX   = 4'd1;
    localparam logic [3:0] ST_PY   = 4'd2;
    localparam logic [3:0] ST_PC   = 4'd3;
    localparam logic [3:0] ST_SQR  = 4'd4;
    localparam logic [3:0] ST_SQI  = 4'd5;
    localparam logic [3:0] ST_CRS  = 4'd6;
    localparam logic [3:0] ST_UPD  = 4'd7;
    localparam logic [3:0] ST_DONE = 4'd8;

    localparam int CB = mbe_pkg::COORD_BITS;

    // config registers
    mbe_pkg::val_t  x_min_reg, y_min_reg;
    mbe_pkg::step_t x_step_reg, y_step_reg;
    mbe_pkg::iter_t max_iter_reg;

    // datapath
    logic [3:0]     state_reg, state_next;
    mbe_pkg::coord_t col_reg, row_reg;
    mbe_pkg::val_t  cx_reg, cy_reg, zr_reg, zi_reg;
    mbe_pkg::val_t  cx_next, cy_next, zr_next, zi_next;
    mbe_pkg::sq_t   sr_reg, si_reg, sr_next, si_next, sq_now, cross_term;
    mbe_pkg::iter_t iter_reg, iter_next;
    mbe_pkg::op_t   op_a, op_b;
    mbe_pkg::prod_t prod_reg;
    mbe_pkg::sum_t  pt_sum, esc_sum;
    logic           m_tvalid_reg, m_tvalid_next;
    mbe_pkg::iter_t out_reg, out_next;
    logic           out_free;

    mbe_mult u_mult (
        .aclk     (aclk),
        .op_a     (op_a),
        .op_b     (op_b),
        .prod_reg (prod_reg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg    <= mbe_pkg::X_MIN_RST;
            x_step_reg   <= mbe_pkg::X_STEP_RST;
            y_min_reg    <= mbe_pkg::Y_MIN_RST;
            y_step_reg   <= mbe_pkg::Y_STEP_RST;
            max_iter_reg <= mbe_pkg::MAX_ITER_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                mbe_pkg::REG_X_MIN:    x_min_reg    <= cfg_wdata[mbe_pkg::VAL_W-1:0];
                mbe_pkg::REG_X_STEP:   x_step_reg   <= cfg_wdata[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_Y_MIN:    y_min_reg    <= cfg_wdata[mbe_pkg::VAL_W-1:0];
                mbe_pkg::REG_Y_STEP:   y_step_reg   <= cfg_wdata[mbe_pkg::STEP_W-1:0];
                mbe_pkg::REG_MAX_ITER: max_iter_reg <= cfg_wdata[mbe_pkg::ITER_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // point coordinate: min + index*step, product is nonnegative
    assign pt_sum = mbe_pkg::sum_t'((state_reg == ST_PY) ? x_min_reg : y_min_reg)
                  + mbe_pkg::sum_t'(prod_reg[mbe_pkg::SUM_W-1:0]);
    assign sq_now = mbe_pkg::sq_t'(prod_reg >>> mbe_pkg::FRAC_BITS);
    assign cross_term = mbe_pkg::sq_t'(prod_reg >>> (mbe_pkg::FRAC_BITS - 1));
    assign esc_sum = mbe_pkg::sum_t'(sr_reg) + mbe_pkg::sum_t'(sq_now);

    // operand select for the shared multiplier
    always_comb begin
        op_a = mbe_pkg::op_t'(zr_reg);
        op_b = mbe_pkg::op_t'(zr_reg);
        unique case (state_reg)
            ST_PX: begin
                op_a = mbe_pkg::op_t'({1'b0, {(mbe_pkg::OP_W-CB-1){1'b0}}, col_reg});
                op_b = mbe_pkg::op_t'({1'b0, x_step_reg});
            end
            ST_PY: begin
                op_a = mbe_pkg::op_t'({1'b0, {(mbe_pkg::OP_W-CB-1){1'b0}}, row_reg});
                op_b = mbe_pkg::op_t'({1'b0, y_step_reg});
            end
            ST_SQI: begin
                op_a = mbe_pkg::op_t'(zi_reg);
                op_b = mbe_pkg::op_t'(zi_reg);
            end
            ST_CRS: begin
                op_a = mbe_pkg::op_t'(zr_reg);
                op_b = mbe_pkg::op_t'(zi_reg);
            end
            default: ;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        zr_next       = zr_reg;
        zi_next       = zi_reg;
        sr_next       = sr_reg;
        si_next       = si_reg;
        iter_next     = iter_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            ST_IDLE: if (s_tvalid) state_next = ST_PX;
            ST_PX:   state_next = ST_PY;
            ST_PY: begin
                cx_next    = mbe_pkg::sat_val(pt_sum);
                zr_next    = mbe_pkg::sat_val(pt_sum);
                state_next = ST_PC;
            end
            ST_PC: begin
                cy_next    = mbe_pkg::sat_val(pt_sum);
                zi_next    = mbe_pkg::sat_val(pt_sum);
                iter_next  = '0;
                state_next = ST_SQR;
            end
            ST_SQR: begin
                if (iter_reg == max_iter_reg) state_next = ST_DONE;
                else                          state_next = ST_SQI;
            end
            ST_SQI: begin
                sr_next    = sq_now;
                state_next = ST_CRS;
            end
            ST_CRS: begin
                si_next = sq_now;
                if (esc_sum > mbe_pkg::ESC_LIMIT) state_next = ST_DONE;
                else                              state_next = ST_UPD;
            end
            ST_UPD: begin
                zi_next    = mbe_pkg::sat_val(mbe_pkg::sum_t'(cross_term)
                                              + mbe_pkg::sum_t'(cy_reg));
                zr_next    = mbe_pkg::sat_val(mbe_pkg::sum_t'(sr_reg) - mbe_pkg::sum_t'(si_reg)
                                              + mbe_pkg::sum_t'(cx_reg));
                iter_next  = iter_reg + mbe_pkg::iter_t'(1);
                state_next = ST_SQR;
            end
            ST_DONE: begin
                if (out_free) begin
                    out_next      = iter_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            col_reg <= s_tdata[CB-1:0];
            row_reg <= s_tdata[2*CB-1:CB];
        end
        cx_reg   <= cx_next;
        cy_reg   <= cy_next;
        zr_reg   <= zr_next;
        zi_reg   <= zi_next;
        sr_reg   <= sr_next;
        si_reg   <= si_next;
        iter_reg <= iter_next;
        out_reg  <= out_next;
    end

    // checks
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_PX))
        else $error("input transfer did not start point setup");

    a_limit_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQR && iter_reg == max_iter_reg) |=> (state_reg == ST_DONE))
        else $error("iteration ran past the limit");

    a_result_from_done: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_done_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && !out_free) |=> (state_reg == ST_DONE && $stable(iter_reg)))
        else $error("finished count lost while output busy");

endmodule

`default_nettype wire

>>> hdl/mbe_mult.sv
// Shared signed multiplier with a registered product.
// Depends on mbe_pkg for operand and product types.
`timescale 1ns / 1ps
`default_nettype none

module mbe_mult (
    input  wire logic         aclk,
    input  wire mbe_pkg::op_t op_a,
    input  wire mbe_pkg::op_t op_b,
    output mbe_pkg::prod_t    prod_reg
);

    mbe_pkg::prod_t prod_next;

    assign prod_next = mbe_pkg::prod_t'(op_a) * mbe_pkg::prod_t'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

endmodule

`default_nettype wire

>>> tb/tb_mandelbrot_escape_count.sv
// Self-checking bench for mandelbrot_escape_count: pixel stream in, iteration counts out.
// Directed plan, then randomized windows; every count is compared to a given value or a local escape-time model.
// Depends on mbe_pkg and the RTL of mandelbrot_escape_count.
`timescale 1ns / 1ps

module tb_mandelbrot_escape_count;

    localparam int     Q_ONE        = 1 << 28;            // 1.0 in Q4.28
    localparam longint Q_MAX        = 64'sd2147483647;
    localparam longint Q_MIN        = -64'sd2147483648;
    localparam longint ESC_Q        = 64'sd4 <<< mbe_pkg::FRAC_BITS;
    localparam int     N_PHASES     = 6;
    localparam int     PHASE_PIXELS = 100;
    localparam int     LIMIT_CYCLES = 10_000_000;
    localparam int     TAIL_CYCLES  = 1100;               // covers a 255-iteration pixel

    // indexes that decode to no register
    localparam logic [mbe_pkg::IDX_W-1:0] REG_UNMAPPED_LO = 3'd5;
    localparam logic [mbe_pkg::IDX_W-1:0] REG_UNMAPPED_HI = 3'd7;

    typedef enum logic {DO_WRITE, DO_PIXEL} act_t;

    typedef struct packed {
        act_t                      act;
        logic [mbe_pkg::IDX_W-1:0] idx;
        logic [mbe_pkg::CFG_W-1:0] val;
        mbe_pkg::coord_t           col;
        mbe_pkg::coord_t           row;
        logic                      known;
        mbe_pkg::iter_t            want;
    } plan_row_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [mbe_pkg::IDX_W-1:0] cfg_index = '0;
    logic [mbe_pkg::CFG_W-1:0] cfg_wdata = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [23:0]               s_tdata   = '0;            // column[11:0], row[23:12]
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;                   // iter_count[15:0]

    // model copy of the register file
    mbe_pkg::val_t  x0       = -32'sd536870912;
    mbe_pkg::step_t dx       = 31'd786432;
    mbe_pkg::val_t  y0       = -32'sd402653184;
    mbe_pkg::step_t dy       = 31'd786432;
    mbe_pkg::iter_t iter_cap = 16'd255;

    mbe_pkg::iter_t pending_counts[$];
    plan_row_t      plan[$];
    int             errors     = 0;
    int             burst_left = 0;
    int             cycles     = 0;
    mbe_pkg::iter_t want_cnt;

    mandelbrot_escape_count DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX) return Q_MAX;
        if (v < Q_MIN) return Q_MIN;
        return v;
    endfunction

    // escape-time count for one pixel under the current register values
    function automatic mbe_pkg::iter_t escape_count(mbe_pkg::coord_t col, mbe_pkg::coord_t row);
        longint      cx, cy, zr, zi, sr, si;
        int unsigned n;
        logic        escaped;
        cx = clamp_q(longint'(x0) + longint'(col) * longint'(dx));
        cy = clamp_q(longint'(y0) + longint'(row) * longint'(dy));
        zr = cx;
        zi = cy;
        n = 0;
        escaped = 1'b0;
        while (!escaped && n < iter_cap) begin
            // >>> on signed longint floors, as the hardware truncation does
            sr = (zr * zr) >>> mbe_pkg::FRAC_BITS;
            si = (zi * zi) >>> mbe_pkg::FRAC_BITS;
            if (sr + si > ESC_Q) begin
                escaped = 1'b1;
            end else begin
                zi = clamp_q(((zr * zi) >>> (mbe_pkg::FRAC_BITS - 1)) + cy);
                zr = clamp_q(sr - si + cx);
                n++;
            end
        end
        return mbe_pkg::iter_t'(n);
    endfunction

    function automatic plan_row_t w_row(logic [mbe_pkg::IDX_W-1:0] idx,
                                        logic [mbe_pkg::CFG_W-1:0] val);
        plan_row_t r;
        r = '0;
        r.act = DO_WRITE;
        r.idx = idx;
        r.val = val;
        return r;
    endfunction

    function automatic plan_row_t p_row(mbe_pkg::coord_t col, mbe_pkg::coord_t row,
                                        logic known, mbe_pkg::iter_t want);
        plan_row_t r;
        r = '0;
        r.act = DO_PIXEL;
        r.col = col;
        r.row = row;
        r.known = known;
        r.want = want;
        return r;
    endfunction

    // block is idle only when no count is outstanding
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_counts.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(logic [mbe_pkg::IDX_W-1:0] idx, logic [mbe_pkg::CFG_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (idx)
            mbe_pkg::REG_X_MIN:    x0 = val;
            mbe_pkg::REG_X_STEP:   dx = val[mbe_pkg::STEP_W-1:0];
            mbe_pkg::REG_Y_MIN:    y0 = val;
            mbe_pkg::REG_Y_STEP:   dy = val[mbe_pkg::STEP_W-1:0];
            mbe_pkg::REG_MAX_ITER: iter_cap = val[mbe_pkg::ITER_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic send_pixel(mbe_pkg::coord_t col, mbe_pkg::coord_t row, logic known,
                              mbe_pkg::iter_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {row, col};
        do @(posedge aclk); while (!s_tready);
        pending_counts.push_back(known ? want : escape_count(col, row));
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_counts.size() == 0) begin
                $display("%0t ns: iter_count expected none, actual %0d", $time, m_tdata);
                errors++;
            end else begin
                want_cnt = pending_counts.pop_front();
                if (m_tdata !== want_cnt) begin
                    $display("%0t ns: iter_count expected %0d, actual %0d",
                             $time, want_cnt, m_tdata);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure, changes character after each random span
    initial begin : sink
        int mode, span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 200);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 7) == 0);
                    default: m_tready <= ~m_tready;
                endcase
            end
        end
    end

    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin : stim
        int p, k;
        logic [mbe_pkg::CFG_W-1:0] cap;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset window: (-2,-1.5) escapes at once, far corner saturates, (-0.5,0) is inside
        plan.push_back(p_row(0, 0, 1'b1, 0));
        plan.push_back(p_row(4095, 4095, 1'b1, 0));
        plan.push_back(p_row(512, 512, 1'b1, 255));
        plan.push_back(p_row(4095, 0, 1'b0, 0));
        plan.push_back(p_row(0, 4095, 1'b0, 0));
        plan.push_back(p_row(300, 700, 1'b0, 0));
        plan.push_back(p_row(200, 512, 1'b0, 0));
        // zero limit
        plan.push_back(w_row(mbe_pkg::REG_MAX_ITER, 32'h0));
        plan.push_back(p_row(512, 512, 1'b1, 0));
        // c = (2,0): |z|^2 equals 4 exactly, so one step before escape
        plan.push_back(w_row(mbe_pkg::REG_X_MIN, 2 * Q_ONE));
        plan.push_back(w_row(mbe_pkg::REG_X_STEP, 32'h8000_0000));
        plan.push_back(w_row(mbe_pkg::REG_Y_MIN, 32'h0));
        plan.push_back(w_row(mbe_pkg::REG_Y_STEP, 32'h8000_0000));
        plan.push_back(w_row(mbe_pkg::REG_MAX_ITER, 32'hFFFF_00FF));
        plan.push_back(p_row(4095, 4095, 1'b1, 1));
        // c = (-2,0) sits on the boundary forever
        plan.push_back(w_row(mbe_pkg::REG_X_MIN, -2 * Q_ONE));
        plan.push_back(p_row(0, 0, 1'b1, 255));
        // origin with the widest limit
        plan.push_back(w_row(mbe_pkg::REG_X_MIN, 32'h0));
        plan.push_back(w_row(mbe_pkg::REG_MAX_ITER, 32'h0000_FFFF));
        plan.push_back(p_row(0, 0, 1'b1, 16'hFFFF));
        // register extremes, point saturation
        plan.push_back(w_row(mbe_pkg::REG_X_MIN, 32'h8000_0000));
        plan.push_back(w_row(mbe_pkg::REG_X_STEP, 32'h7FFF_FFFF));
        plan.push_back(w_row(mbe_pkg::REG_Y_MIN, 32'h7FFF_FFFF));
        plan.push_back(w_row(mbe_pkg::REG_Y_STEP, 32'hFFFF_FFFF));
        plan.push_back(w_row(REG_UNMAPPED_LO, 32'h0));
        plan.push_back(p_row(0, 0, 1'b1, 0));
        plan.push_back(p_row(4095, 0, 1'b1, 0));

        for (k = 0; k < plan.size(); k++) begin
            if (plan[k].act == DO_WRITE) begin
                wait_idle();
                write_reg(plan[k].idx, plan[k].val);
            end else begin
                send_pixel(plan[k].col, plan[k].row, plan[k].known, plan[k].want);
            end
        end

        for (p = 0; p < N_PHASES; p++) begin
            wait_idle();
            cap = (p == 1) ? 32'd255 : $urandom_range(1, 64);
            if (p == N_PHASES - 1) begin
                // anything goes: mostly saturated points that escape at once
                write_reg(mbe_pkg::REG_X_MIN, $urandom);
                write_reg(mbe_pkg::REG_X_STEP, $urandom);
                write_reg(mbe_pkg::REG_Y_MIN, $urandom);
                write_reg(mbe_pkg::REG_Y_STEP, $urandom);
                cap = $urandom_range(0, 255);
            end else begin
                // window around the set so counts spread from 0 to the limit
                write_reg(mbe_pkg::REG_X_MIN,
                          -(5 * Q_ONE / 2) + int'($urandom_range(0, 2 * Q_ONE)));
                write_reg(mbe_pkg::REG_X_STEP,
                          ($urandom & 32'h8000_0000) | $urandom_range(1 << 16, 1 << 18));
                write_reg(mbe_pkg::REG_Y_MIN,
                          -2 * Q_ONE + int'($urandom_range(0, 3 * Q_ONE / 2)));
                write_reg(mbe_pkg::REG_Y_STEP,
                          ($urandom & 32'h8000_0000) | $urandom_range(1 << 16, 1 << 18));
            end
            write_reg(mbe_pkg::REG_MAX_ITER, ($urandom & 32'hFFFF_0000) | cap);
            write_reg(mbe_pkg::IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                      $urandom);
            for (k = 0; k < PHASE_PIXELS; k++) begin
                if ($urandom_range(0, 63) == 0) wait_idle();
                send_pixel(mbe_pkg::coord_t'($urandom_range(0, 4095)),
                           mbe_pkg::coord_t'($urandom_range(0, 4095)), 1'b0, 0);
            end
        end

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
